/* sv/mfpic_pkg.sv */
// Shared types and constants for the 16-channel interrupt controller.
// Used by mfpic_deliver, mfpic_exec and mfp_interrupt_controller_core.
package mfpic_pkg;

   // Operation carried by one request transaction
   typedef enum logic [2:0] {
      OP_WRITE = 3'd0,
      OP_READ  = 3'd1,
      OP_RAISE = 3'd2,
      OP_TIMER = 3'd3,
      OP_IACK  = 3'd4
   } op_type;

   // Register window and byte addresses
   localparam logic [23:0] WIN_LO    = 24'hFFFA00;
   localparam logic [23:0] WIN_HI    = 24'hFFFA2F;
   localparam logic [23:0] ADDR_IERA = 24'hFFFA07;
   localparam logic [23:0] ADDR_IERB = 24'hFFFA09;
   localparam logic [23:0] ADDR_IPRA = 24'hFFFA0B;
   localparam logic [23:0] ADDR_IPRB = 24'hFFFA0D;
   localparam logic [23:0] ADDR_ISRA = 24'hFFFA0F;
   localparam logic [23:0] ADDR_ISRB = 24'hFFFA11;
   localparam logic [23:0] ADDR_IMRA = 24'hFFFA13;
   localparam logic [23:0] ADDR_IMRB = 24'hFFFA15;
   localparam logic [23:0] ADDR_VR   = 24'hFFFA17;
   localparam logic [23:0] ADDR_TACR = 24'hFFFA19;
   localparam logic [23:0] ADDR_TADR = 24'hFFFA1F;

   localparam int          VR_SEOI_BIT     = 3;
   localparam logic [7:0]  VR_RESET        = 8'h48;
   localparam logic [3:0]  TIMER_CH        = 4'd13;
   localparam logic [3:0]  TIMER_EVENT_MODE = 4'd8;
   localparam logic [8:0]  TIMER_RESET     = 9'd256;

   // One request
   typedef struct packed {
      op_type      op;
      logic [23:0] bus_address;
      logic        is_word;
      logic [7:0]  write_data;
      logic [7:0]  real_read_data;
      logic [3:0]  channel;
      logic [15:0] level_lines;
   } req_type;

   // One response
   typedef struct packed {
      logic       irq_wanted;
      logic [7:0] ack_vector;
      logic       ack_valid;
      logic [7:0] read_data;
   } rsp_type;

   // Controller state
   typedef struct packed {
      logic [15:0] enable_bits;
      logic [15:0] mask_bits;
      logic [15:0] pending_bits;
      logic [15:0] in_service_bits;
      logic [7:0]  vector_register;
      logic [3:0]  timer_a_mode;
      logic [8:0]  timer_a_reload;
      logic [8:0]  timer_a_count;
   } state_type;

   // Outcome of the priority search
   typedef struct packed {
      logic       any;
      logic [3:0] chan;
   } deliver_type;

endpackage

/* sv/mfpic_deliver.sv */
// Priority search: finds the highest deliverable channel for a given state.
// Depends on mfpic_pkg.
module mfpic_deliver (
   input  mfpic_pkg::state_type   state,
   input  logic [15:0]            level_lines,
   output mfpic_pkg::deliver_type result
);
   import mfpic_pkg::*;

   logic [15:0] cand;
   logic [15:0] isr_smear;

   // Smear the in-service word downwards: bits at or below the top in-service
   // channel are blocked
   always_comb begin
      isr_smear = state.in_service_bits;
      isr_smear = isr_smear | (isr_smear >> 1);
      isr_smear = isr_smear | (isr_smear >> 2);
      isr_smear = isr_smear | (isr_smear >> 4);
      isr_smear = isr_smear | (isr_smear >> 8);
      cand = (state.pending_bits | level_lines) & state.enable_bits
             & state.mask_bits & ~isr_smear;
   end

   // Highest set candidate wins
   always_comb begin
      result.any  = |cand;
      result.chan = '0;
      for (int i = 0; i < 16; i++) begin
         if (cand[i]) begin
            result.chan = 4'(i);
         end
      end
   end

endmodule

/* sv/mfpic_exec.sv */
// Execute stage: holds the controller state and applies one transaction per step.
// Depends on mfpic_pkg and mfpic_deliver.
module mfpic_exec (
   input  logic               clock,
   input  logic               reset,
   input  logic               step,
   input  mfpic_pkg::req_type req,
   output mfpic_pkg::rsp_type rsp
);
   import mfpic_pkg::*;

   state_type   state_ff, state_in;
   deliver_type pre_dlv, post_dlv;
   logic [23:0] eff_addr;
   logic        in_window;
   logic [15:0] pend_view;
   logic [15:0] bit_sel;
   logic [15:0] raise_bit;

   // Search before the step (for acknowledge) and after it (for irq_wanted)
   mfpic_deliver u_pre (
      .state       (state_ff),
      .level_lines (req.level_lines),
      .result      (pre_dlv)
   );

   mfpic_deliver u_post (
      .state       (state_in),
      .level_lines (req.level_lines),
      .result      (post_dlv)
   );

   assign in_window = (req.bus_address >= WIN_LO) && (req.bus_address <= WIN_HI);
   assign eff_addr  = req.is_word ? (req.bus_address | 24'h000001) : req.bus_address;
   assign pend_view = (state_ff.pending_bits | req.level_lines) & state_ff.enable_bits;
   assign bit_sel   = 16'(1) << pre_dlv.chan;

   // Next state and response
   always_comb begin
      state_in      = state_ff;
      rsp           = '0;
      raise_bit     = '0;
      case (req.op)
         OP_WRITE: begin
            if (in_window) begin
               case (eff_addr)
                  ADDR_IERA: begin
                     state_in.enable_bits[15:8] = req.write_data;
                     state_in.pending_bits = state_ff.pending_bits & state_in.enable_bits;
                  end
                  ADDR_IERB: begin
                     state_in.enable_bits[7:0] = req.write_data;
                     state_in.pending_bits = state_ff.pending_bits & state_in.enable_bits;
                  end
                  ADDR_IPRA: state_in.pending_bits[15:8] =
                                state_ff.pending_bits[15:8] & req.write_data;
                  ADDR_IPRB: state_in.pending_bits[7:0] =
                                state_ff.pending_bits[7:0] & req.write_data;
                  ADDR_ISRA: state_in.in_service_bits[15:8] =
                                state_ff.in_service_bits[15:8] & req.write_data;
                  ADDR_ISRB: state_in.in_service_bits[7:0] =
                                state_ff.in_service_bits[7:0] & req.write_data;
                  ADDR_IMRA: state_in.mask_bits[15:8] = req.write_data;
                  ADDR_IMRB: state_in.mask_bits[7:0]  = req.write_data;
                  ADDR_VR: begin
                     state_in.vector_register = req.write_data;
                     // auto end-of-interrupt drops everything in service
                     if (!req.write_data[VR_SEOI_BIT]) begin
                        state_in.in_service_bits = '0;
                     end
                  end
                  ADDR_TACR: begin
                     state_in.timer_a_mode  = req.write_data[3:0];
                     state_in.timer_a_count = state_ff.timer_a_reload;
                  end
                  ADDR_TADR: begin
                     // a zero data byte means a full count of 256
                     state_in.timer_a_reload = {(req.write_data == 8'd0), req.write_data};
                     state_in.timer_a_count  = {(req.write_data == 8'd0), req.write_data};
                  end
                  default: ;
               endcase
            end
         end
         OP_READ: begin
            case (req.bus_address)
               ADDR_IPRA: rsp.read_data = req.real_read_data | pend_view[15:8];
               ADDR_IPRB: rsp.read_data = req.real_read_data | pend_view[7:0];
               ADDR_ISRA: rsp.read_data = req.real_read_data | state_ff.in_service_bits[15:8];
               ADDR_ISRB: rsp.read_data = req.real_read_data | state_ff.in_service_bits[7:0];
               default:   rsp.read_data = req.real_read_data;
            endcase
         end
         OP_RAISE: begin
            raise_bit = (16'(1) << req.channel) & state_ff.enable_bits;
            state_in.pending_bits = state_ff.pending_bits | raise_bit;
         end
         OP_TIMER: begin
            if (state_ff.timer_a_mode == TIMER_EVENT_MODE) begin
               if (state_ff.timer_a_count[8:1] == 8'd0) begin
                  // expiry: reload and raise the timer channel if enabled
                  state_in.timer_a_count = state_ff.timer_a_reload;
                  raise_bit = (16'(1) << TIMER_CH) & state_ff.enable_bits;
                  state_in.pending_bits = state_ff.pending_bits | raise_bit;
               end else begin
                  state_in.timer_a_count = state_ff.timer_a_count - 9'd1;
               end
            end
         end
         OP_IACK: begin
            if (pre_dlv.any) begin
               state_in.pending_bits = state_ff.pending_bits & ~bit_sel;
               if (state_ff.vector_register[VR_SEOI_BIT]) begin
                  state_in.in_service_bits = state_ff.in_service_bits | bit_sel;
               end
               rsp.ack_valid  = 1'b1;
               rsp.ack_vector = {state_ff.vector_register[7:4], pre_dlv.chan};
            end
         end
         default: ;
      endcase
      rsp.irq_wanted = post_dlv.any;
   end

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.enable_bits     <= 16'hFFFF;
         state_ff.mask_bits       <= 16'hFFFF;
         state_ff.pending_bits    <= '0;
         state_ff.in_service_bits <= '0;
         state_ff.vector_register <= VR_RESET;
         state_ff.timer_a_mode    <= '0;
         state_ff.timer_a_reload  <= TIMER_RESET;
         state_ff.timer_a_count   <= TIMER_RESET;
      end else if (step) begin
         state_ff <= state_in;
      end
   end

endmodule

/* sv/mfp_interrupt_controller_core.sv */
// 16-channel interrupt controller in the style of a 68901: every request
// transaction (bus write, bus read, channel raise, Timer A event, interrupt
// acknowledge) yields exactly one response transaction. A transaction is
// registered on entry, then executed against the controller state once the
// output register is free or being emptied, and its response is held in an
// output register; one transaction is taken every clock cycle while the
// response side keeps up. Throughput is set by the single execute stage,
// which updates all state at once.
// Depends on mfpic_pkg and mfpic_exec.
module mfp_interrupt_controller_core (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   // tdata: bus_address[23:0], is_word[24], write_data[32:25],
   //        real_read_data[40:33], channel[44:41], level_lines[60:45], zero[63:61]
   input  logic [63:0] req_tdata,
   // tuser: op[2:0]
   input  logic [2:0]  req_tuser,
   // response channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // tdata: read_data[7:0], ack_valid[8], ack_vector[16:9], irq_wanted[17],
   //        zero[23:18]
   output logic [23:0] rsp_tdata
);
   import mfpic_pkg::*;

   req_type in_ff, in_in;
   logic    in_valid_ff, in_valid_in;
   rsp_type rsp_ff, rsp_in;
   logic    out_valid_ff, out_valid_in;
   logic    step;
   logic    req_take;

   // Pipeline control
   assign step       = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || step;
   assign req_take   = req_tvalid && req_tready;

   // Unpack the incoming transaction
   always_comb begin
      in_in.op             = op_type'(req_tuser[2:0]);
      in_in.bus_address    = req_tdata[23:0];
      in_in.is_word        = req_tdata[24];
      in_in.write_data     = req_tdata[32:25];
      in_in.real_read_data = req_tdata[40:33];
      in_in.channel        = req_tdata[44:41];
      in_in.level_lines    = req_tdata[60:45];
   end

   assign in_valid_in  = req_take ? 1'b1 : (step ? 1'b0 : in_valid_ff);
   assign out_valid_in = step ? 1'b1 : (rsp_tready ? 1'b0 : out_valid_ff);

   mfpic_exec u_exec (
      .clock (clock),
      .reset (reset),
      .step  (step),
      .req   (in_ff),
      .rsp   (rsp_in)
   );

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_ff <= in_in;
      end
      if (step) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {6'd0, rsp_ff.irq_wanted, rsp_ff.ack_vector,
                        rsp_ff.ack_valid, rsp_ff.read_data};

   // Checks
   a_stall_only_when_blocked: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (in_valid_ff && out_valid_ff && !rsp_tready))
      else $error("input stalled without a blocked response");

   a_step_fills_output: assert property (@(posedge clock) disable iff (reset)
      step |=> out_valid_ff)
      else $error("executed transaction did not reach the output register");

   a_no_vector_without_ack: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp_ff.ack_valid) |-> (rsp_ff.ack_vector == 8'd0))
      else $error("vector present without a valid acknowledge");

endmodule
